@@ design/lfp_pkg.sv @@
// Package for the LED fade and PWM driver: command and direction codes,
// the per-step control struct and the gamma table.
// No dependencies; every other file of the block depends on it.
package lfp_pkg;

	localparam int LED_COUNT_DEF = 8;
	localparam int SLOT_MAX = 8;

	localparam int CMD_W = 2;
	localparam int IDX_W = 3;
	localparam int MASK_W = 8;
	localparam int LEVEL_W = 5;
	localparam int PHASE_W = 8;

	localparam logic [CMD_W-1:0] CMD_SET = 2'd0;
	localparam logic [CMD_W-1:0] CMD_FADE = 2'd1;
	localparam logic [CMD_W-1:0] CMD_PWM = 2'd2;

	localparam logic [1:0] DIR_STABLE = 2'd0;
	localparam logic [1:0] DIR_UP = 2'd1;
	localparam logic [1:0] DIR_DOWN = 2'd2;

	localparam logic [LEVEL_W-1:0] LEVEL_MAX = 5'd16;
	localparam logic [PHASE_W-1:0] PWM_PERIOD = 8'd193;

	// Broadcast to every LED slot for the item that is being applied.
	typedef struct packed {
		logic set_en;
		logic led_on;
		logic fade_en;
		logic pwm_en;
		logic wrap;
		logic [PHASE_W-1:0] phase;
	} lfp_ctl_t;

	function automatic logic [PHASE_W-1:0] gamma_lut(input logic [LEVEL_W-1:0] lv);
		logic [PHASE_W-1:0] g;
		case (lv)
			5'd0: g = 8'd0;
			5'd1: g = 8'd1;
			5'd2: g = 8'd1;
			5'd3: g = 8'd2;
			5'd4: g = 8'd3;
			5'd5: g = 8'd4;
			5'd6: g = 8'd6;
			5'd7: g = 8'd8;
			5'd8: g = 8'd12;
			5'd9: g = 8'd16;
			5'd10: g = 8'd24;
			5'd11: g = 8'd32;
			5'd12: g = 8'd48;
			5'd13: g = 8'd64;
			5'd14: g = 8'd96;
			5'd15: g = 8'd128;
			default: g = 8'd192;
		endcase
		return g;
	endfunction

endpackage

@@ design/lfp_if.sv @@
// Valid/ready channel interfaces for the LED fade and PWM driver:
// the command channel and the status result channel.
// Depends on lfp_pkg for field widths.
interface lfp_cmd_if;
	logic valid;
	logic ready;
	logic [lfp_pkg::CMD_W-1:0] command;
	logic [lfp_pkg::IDX_W-1:0] led_index;
	logic led_on;

	modport source(output valid, command, led_index, led_on, input ready);
	modport sink(input valid, command, led_index, led_on, output ready);
endinterface

interface lfp_res_if;
	logic valid;
	logic ready;
	logic [lfp_pkg::MASK_W-1:0] pin_levels;
	logic [lfp_pkg::MASK_W-1:0] stable_mask;
	logic all_stable;

	modport source(output valid, pin_levels, stable_mask, all_stable, input ready);
	modport sink(input valid, pin_levels, stable_mask, all_stable, output ready);
endinterface

@@ design/lfp_phase.sv @@
// PWM phase counter with a period of 193 ticks.
// Depends on lfp_pkg for widths and the period constant.
module lfp_phase (
	input  logic clk,
	input  logic arst_n,
	input  logic tick,
	output logic wrap,
	output logic [lfp_pkg::PHASE_W-1:0] phase
);
	import lfp_pkg::*;

	logic [PHASE_W-1:0] phase_q;

	// The phase seen by the LEDs is the value after the wrap check.
	assign wrap = (phase_q >= PWM_PERIOD);
	assign phase = wrap ? '0 : phase_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
		end else if (tick) begin
			phase_q <= phase + 8'd1;
		end
	end
endmodule

@@ design/lfp_led_slot.sv @@
// State of one LED slot: target, fade level and direction, pin drive.
// Gives the next pin and stable values for the result. Depends on lfp_pkg.
module lfp_led_slot (
	input  logic clk,
	input  logic arst_n,
	input  logic step,
	input  logic hit,
	input  logic present,
	input  lfp_pkg::lfp_ctl_t ctl,
	output logic pin_next,
	output logic stable_next
);
	import lfp_pkg::*;

	logic target_q;
	logic [1:0] dir_q;
	logic [LEVEL_W-1:0] level_q;
	logic pin_q;

	logic target_d;
	logic [1:0] dir_d;
	logic [LEVEL_W-1:0] level_d;
	logic pin_d;
	logic [LEVEL_W-1:0] level_clamp;

	assign level_clamp = (level_q > LEVEL_MAX) ? LEVEL_MAX : level_q;

	always_comb begin
		target_d = target_q;
		dir_d = dir_q;
		level_d = level_q;
		pin_d = pin_q;
		if (ctl.set_en && hit && (target_q != ctl.led_on)) begin
			target_d = ctl.led_on;
			dir_d = ctl.led_on ? DIR_UP : DIR_DOWN;
		end
		if (ctl.fade_en && present) begin
			case (dir_q)
				DIR_DOWN: begin
					if (level_q == '0) dir_d = DIR_STABLE;
					else level_d = level_q - 5'd1;
				end
				DIR_UP: begin
					if (level_q >= LEVEL_MAX) begin
						level_d = LEVEL_MAX;
						dir_d = DIR_STABLE;
					end else begin
						level_d = level_q + 5'd1;
					end
				end
				default: ;
			endcase
		end
		if (ctl.pwm_en && present) begin
			if (ctl.wrap) pin_d = 1'b1;
			if ((PWM_PERIOD - gamma_lut(level_clamp)) == ctl.phase) pin_d = 1'b0;
		end
	end

	assign pin_next = pin_d;
	assign stable_next = (dir_d == DIR_STABLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q <= 1'b0;
			dir_q <= DIR_STABLE;
			level_q <= '0;
			pin_q <= 1'b1;
		end else if (step) begin
			target_q <= target_d;
			dir_q <= dir_d;
			level_q <= level_d;
			pin_q <= pin_d;
		end
	end
endmodule

@@ design/led_fade_pwm_driver.sv @@
// LED fade and PWM driver, top level. A command transfer is registered in
// stage 1; when it moves on, the LED state and the result register are
// updated together, and the result is then offered on the result channel.
// Throughput: one command per cycle while the result side does not stall; the per-LED logic is replicated.
// Reset (arst_n low, asynchronous): all LEDs dark and stable, pins high,
// PWM phase zero, present mask all ones, both channels empty.
module led_fade_pwm_driver #(
	parameter int LED_COUNT = lfp_pkg::LED_COUNT_DEF
) (
	input  logic clk,
	input  logic arst_n,
	lfp_cmd_if.sink cmd_ch,
	lfp_res_if.source res_ch,
	input  logic cfg_we,
	input  logic [lfp_pkg::MASK_W-1:0] cfg_wdata
);
	import lfp_pkg::*;

	localparam int SLOT_NUM = (LED_COUNT > SLOT_MAX) ? SLOT_MAX : LED_COUNT;

	logic [MASK_W-1:0] present_q;

	logic s1_valid_q;
	logic [CMD_W-1:0] command_s1;
	logic [IDX_W-1:0] led_index_s1;
	logic led_on_s1;

	logic res_valid_q;
	logic [MASK_W-1:0] pin_levels_s2;
	logic [MASK_W-1:0] stable_mask_s2;
	logic all_stable_s2;

	logic out_free;
	logic s1_move;
	logic wrap;
	logic [PHASE_W-1:0] phase;
	lfp_ctl_t ctl;
	logic [MASK_W-1:0] pin_next;
	logic [MASK_W-1:0] stable_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) present_q <= '1;
		else if (cfg_we) present_q <= cfg_wdata;
	end

	assign out_free = !res_valid_q || res_ch.ready;
	assign s1_move = s1_valid_q && out_free;
	assign cmd_ch.ready = !s1_valid_q || out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) s1_valid_q <= 1'b0;
		else if (cmd_ch.ready) s1_valid_q <= cmd_ch.valid;
	end

	always_ff @(posedge clk) begin
		if (cmd_ch.ready && cmd_ch.valid) begin
			command_s1 <= cmd_ch.command;
			led_index_s1 <= cmd_ch.led_index;
			led_on_s1 <= cmd_ch.led_on;
		end
	end

	lfp_phase u_phase (
		.clk   (clk),
		.arst_n(arst_n),
		.tick  (s1_move && (command_s1 == CMD_PWM)),
		.wrap  (wrap),
		.phase (phase)
	);

	always_comb begin
		ctl.set_en = (command_s1 == CMD_SET);
		ctl.led_on = led_on_s1;
		ctl.fade_en = (command_s1 == CMD_FADE);
		ctl.pwm_en = (command_s1 == CMD_PWM);
		ctl.wrap = wrap;
		ctl.phase = phase;
	end

	for (genvar i = 0; i < MASK_W; i++) begin : g_slot
		if (i < SLOT_NUM) begin : g_led
			lfp_led_slot u_slot (
				.clk        (clk),
				.arst_n     (arst_n),
				.step       (s1_move),
				.hit        (led_index_s1 == IDX_W'(i)),
				.present    (present_q[i]),
				.ctl        (ctl),
				.pin_next   (pin_next[i]),
				.stable_next(stable_next[i])
			);
		end else begin : g_none
			// Slots that are not built read as an idle, dark LED.
			assign pin_next[i] = 1'b1;
			assign stable_next[i] = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) res_valid_q <= 1'b0;
		else if (out_free) res_valid_q <= s1_valid_q;
	end

	always_ff @(posedge clk) begin
		if (s1_move) begin
			pin_levels_s2 <= pin_next;
			stable_mask_s2 <= stable_next;
			all_stable_s2 <= ((stable_next | ~present_q) == '1);
		end
	end

	assign res_ch.valid = res_valid_q;
	assign res_ch.pin_levels = pin_levels_s2;
	assign res_ch.stable_mask = stable_mask_s2;
	assign res_ch.all_stable = all_stable_s2;

	// A registered command must not be lost while the result side stalls.
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid_q && !out_free |=> s1_valid_q)
		else $error("command dropped while result stalled");

	// Every applied command shows up as a result in the next cycle.
	a_apply_result: assert property (@(posedge clk) disable iff (!arst_n)
		s1_move |=> res_ch.valid)
		else $error("applied command produced no result");

	// A taken result with nothing behind it must not be shown again.
	a_no_repeat: assert property (@(posedge clk) disable iff (!arst_n)
		res_ch.valid && res_ch.ready && !s1_move |=> !res_ch.valid)
		else $error("result repeated after transfer");
endmodule
